// ===== rtl/core/bmp_pkg.sv =====
// Package for the binomial coefficient block: field widths, the prime,
// the fold constant for modular reduction, status codes and pipeline side data.
// No dependencies.
package bmp_pkg;

  localparam int N_W   = 12;
  localparam int RES_W = 20;
  localparam int ST_W  = 2;

  // The largest argument plus one; no table entry beyond it is ever read.
  localparam int ARG_SPAN = 1 << N_W;

  localparam int TABLE_DEPTH_DEFAULT = 4096;

  localparam logic [RES_W-1:0] PRIME = 20'd1000003;

  // 2^20 is congruent to this value modulo the prime.
  localparam logic [15:0] FOLD_K = 16'((1 << RES_W) - 1000003);

  // Fermat exponent for the modular inverse.
  localparam logic [RES_W-1:0] INV_EXP = 20'(1000003 - 2);

  // Register stages inside one modular multiplier.
  localparam int MM_STAGES = 7;

  typedef enum logic [ST_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_R_GT_N   = 2'd1,
    STATUS_N_BEYOND = 2'd2
  } status_e;

  // Data that travels beside the running product through the inverse chain.
  typedef struct packed {
    logic [RES_W-1:0] base;
    logic [RES_W-1:0] fn;
    logic [ST_W-1:0]  status;
  } chain_t;

endpackage

// ===== rtl/core/bmp_if.sv =====
// Handshake channels of the binomial block: the query and the result.
// Depends on bmp_pkg for field widths.
interface bmp_query_if;
  logic                    valid;
  logic                    ready;
  logic [bmp_pkg::N_W-1:0] n_value;
  logic [bmp_pkg::N_W-1:0] r_value;

  modport source (output valid, output n_value, output r_value, input ready);
  modport sink   (input valid, input n_value, input r_value, output ready);
endinterface

interface bmp_result_if;
  logic                      valid;
  logic                      ready;
  logic [bmp_pkg::RES_W-1:0] binomial_result;
  logic [bmp_pkg::ST_W-1:0]  status_code;

  modport source (output valid, output binomial_result, output status_code, input ready);
  modport sink   (input valid, input binomial_result, input status_code, output ready);
endinterface

// ===== rtl/core/bmp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bmp_modmul.sv =====
// Pipelined multiplier modulo the prime: one product stage, five fold stages
// and a final fold with conditional subtract. Carries side data alongside.
// Depends on bmp_pkg.
module bmp_modmul #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [bmp_pkg::RES_W-1:0] a_i,
  input  logic [bmp_pkg::RES_W-1:0] b_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [bmp_pkg::RES_W-1:0] prod_o,
  output logic [SIDE_W-1:0]         side_o
);

  logic [bmp_pkg::MM_STAGES-1:0] valid_q;
  logic [SIDE_W-1:0]             side_q [bmp_pkg::MM_STAGES];

  logic [39:0] s1_q;
  logic [36:0] s2_q, s2_d;
  logic [32:0] s3_q, s3_d;
  logic [28:0] s4_q, s4_d;
  logic [24:0] s5_q, s5_d;
  logic [21:0] s6_q, s6_d;
  logic [20:0] fold7;
  logic [bmp_pkg::RES_W-1:0] s7_q, s7_d;

  // Each fold replaces the bits above 2^20 by their weight modulo the prime.
  always_comb begin
    s2_d  = 37'(s1_q[39:20]) * 37'(bmp_pkg::FOLD_K) + 37'(s1_q[19:0]);
    s3_d  = 33'(s2_q[36:20]) * 33'(bmp_pkg::FOLD_K) + 33'(s2_q[19:0]);
    s4_d  = 29'(s3_q[32:20]) * 29'(bmp_pkg::FOLD_K) + 29'(s3_q[19:0]);
    s5_d  = 25'(s4_q[28:20]) * 25'(bmp_pkg::FOLD_K) + 25'(s4_q[19:0]);
    s6_d  = 22'(s5_q[24:20]) * 22'(bmp_pkg::FOLD_K) + 22'(s5_q[19:0]);
    fold7 = 21'(s6_q[21:20]) * 21'(bmp_pkg::FOLD_K) + 21'(s6_q[19:0]);
    // The last fold stays below twice the prime.
    if (fold7 >= 21'(bmp_pkg::PRIME)) begin
      s7_d = 20'(fold7 - 21'(bmp_pkg::PRIME));
    end else begin
      s7_d = fold7[19:0];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[bmp_pkg::MM_STAGES-2:0], valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= 40'(a_i) * 40'(b_i);
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      s7_q <= s7_d;
      side_q[0] <= side_i;
      for (int k = 1; k < bmp_pkg::MM_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[bmp_pkg::MM_STAGES-1];
  assign prod_o  = s7_q;
  assign side_o  = side_q[bmp_pkg::MM_STAGES-1];

endmodule

// ===== rtl/core/binomial_mod_prime.sv =====
// Top level of the binomial coefficient block modulo 1000003.
// Depends on bmp_pkg, bmp_if, bmp_ram and bmp_modmul.
//
// Usage: a query item carries n_value and r_value; each query gives exactly
// one result item with binomial_result and status_code. Status 2 means n is
// past the factorial table, status 1 means r is greater than n; both return
// zero. Both channels use valid/ready; an item moves when both are high.
// After reset the block fills its factorial table through one modular
// multiplier, one entry at a time, each entry waiting for the product of the
// one before; query ready stays low until the fill ends.
// Once filled, a query enters every cycle unless the result receiver stalls.
// A query passes one table read, then 28 modular multipliers of seven stages
// each (the denominator product, 19 squarings and 7 multiplies of the Fermat
// inverse, and the final product with n!). While the result receiver stalls,
// the whole pipeline holds and query ready is low; nothing is lost or repeated.
module binomial_mod_prime #(
  parameter int TABLE_DEPTH = bmp_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bmp_query_if.sink           query_i,
  bmp_result_if.source        result_o
);

  localparam int MEM_DEPTH = (TABLE_DEPTH < bmp_pkg::ARG_SPAN) ? TABLE_DEPTH
                                                               : bmp_pkg::ARG_SPAN;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = $bits(bmp_pkg::chain_t);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_WAIT,
    ST_READY
  } fill_state_e;

  fill_state_e state_q;
  logic [AW-1:0]             idx_q;
  logic [bmp_pkg::RES_W-1:0] fact_q;
  logic                      issue_q;

  logic                      fill_v;
  logic [bmp_pkg::RES_W-1:0] fill_prod;
  logic [0:0]                fill_side;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [bmp_pkg::RES_W-1:0] wdata;
  logic                      table_ready;

  logic                      en;
  logic                      accept;
  logic [bmp_pkg::ST_W-1:0]  status_d;
  logic [bmp_pkg::N_W-1:0]   diff;
  logic                      valid0_q;
  logic [bmp_pkg::ST_W-1:0]  status0_q;
  logic [bmp_pkg::RES_W-1:0] rd_n, rd_r, rd_nr;
  bmp_pkg::chain_t           side0;
  bmp_pkg::chain_t           den_ch;

  logic                      v_c   [20];
  logic [bmp_pkg::RES_W-1:0] acc_c [20];
  bmp_pkg::chain_t           ch_c  [20];

  logic                      out_v;
  logic [bmp_pkg::RES_W-1:0] out_prod;
  bmp_pkg::chain_t           out_ch;

  // Fill sequencer: entry i = i * entry (i-1), one multiply in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      fact_q  <= '0;
      issue_q <= 1'b0;
    end else begin
      issue_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          idx_q   <= AW'(1);
          fact_q  <= bmp_pkg::RES_W'(1);
          issue_q <= 1'b1;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (fill_v) begin
            if (fill_side[0]) begin
              state_q <= ST_READY;
            end else begin
              idx_q   <= idx_q + AW'(1);
              fact_q  <= fill_prod;
              issue_q <= 1'b1;
            end
          end
        end
        ST_READY: begin
          state_q <= ST_READY;
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  // The side bit marks the product of the last table entry.
  bmp_modmul #(.SIDE_W(1)) u_fill_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .valid_i (issue_q),
    .a_i     (bmp_pkg::RES_W'(idx_q)),
    .b_i     (fact_q),
    .side_i  (idx_q == AW'(MEM_DEPTH - 1)),
    .valid_o (fill_v),
    .prod_o  (fill_prod),
    .side_o  (fill_side)
  );

  // Table write port: entry zero first, then each product as it returns.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = fill_prod;
    if (state_q == ST_INIT) begin
      we    = 1'b1;
      waddr = '0;
      wdata = bmp_pkg::RES_W'(1);
    end else if (state_q == ST_WAIT && fill_v) begin
      we = 1'b1;
    end
  end

  assign table_ready = (state_q == ST_READY);

  // The whole query pipeline advances unless a finished result is stalled.
  assign en            = !out_v || result_o.ready;
  assign query_i.ready = en && table_ready;
  assign accept        = query_i.valid && query_i.ready;
  assign diff          = query_i.n_value - query_i.r_value;

  // Range checks; the n test comes first.
  always_comb begin
    if (32'(query_i.n_value) >= 32'(TABLE_DEPTH)) begin
      status_d = bmp_pkg::STATUS_N_BEYOND;
    end else if (query_i.r_value > query_i.n_value) begin
      status_d = bmp_pkg::STATUS_R_GT_N;
    end else begin
      status_d = bmp_pkg::STATUS_OK;
    end
  end

  // Three copies of the table give n!, r! and (n-r)! in the same cycle.
  bmp_ram #(.WIDTH(bmp_pkg::RES_W), .DEPTH(MEM_DEPTH)) u_ram_n (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (en), .raddr_i (query_i.n_value[AW-1:0]), .rdata_o (rd_n)
  );
  bmp_ram #(.WIDTH(bmp_pkg::RES_W), .DEPTH(MEM_DEPTH)) u_ram_r (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (en), .raddr_i (query_i.r_value[AW-1:0]), .rdata_o (rd_r)
  );
  bmp_ram #(.WIDTH(bmp_pkg::RES_W), .DEPTH(MEM_DEPTH)) u_ram_nr (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wdata),
    .re_i (en), .raddr_i (diff[AW-1:0]), .rdata_o (rd_nr)
  );

  // Read stage control, aligned with the registered table data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (en) begin
      valid0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status0_q <= status_d;
    end
  end

  assign side0 = '{base: '0, fn: rd_n, status: status0_q};

  // Denominator r! * (n-r)!, which is also the base of the inverse.
  bmp_modmul #(.SIDE_W(CW)) u_den_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid0_q),
    .a_i     (rd_r),
    .b_i     (rd_nr),
    .side_i  (side0),
    .valid_o (v_c[19]),
    .prod_o  (acc_c[19]),
    .side_o  (den_ch)
  );

  // The top exponent bit is one, so the running product starts at the base.
  assign ch_c[19] = '{base: acc_c[19], fn: den_ch.fn, status: den_ch.status};

  // Square and multiply, one exponent bit per block; block k takes bit k.
  for (genvar k = 0; k < 19; k++) begin : g_exp
    logic                      sq_v;
    logic [bmp_pkg::RES_W-1:0] sq_acc;
    bmp_pkg::chain_t           sq_ch;

    bmp_modmul #(.SIDE_W(CW)) u_sq (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[k+1]),
      .a_i     (acc_c[k+1]),
      .b_i     (acc_c[k+1]),
      .side_i  (ch_c[k+1]),
      .valid_o (sq_v),
      .prod_o  (sq_acc),
      .side_o  (sq_ch)
    );

    if (bmp_pkg::INV_EXP[k]) begin : g_mul
      bmp_modmul #(.SIDE_W(CW)) u_mul (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (sq_v),
        .a_i     (sq_acc),
        .b_i     (sq_ch.base),
        .side_i  (sq_ch),
        .valid_o (v_c[k]),
        .prod_o  (acc_c[k]),
        .side_o  (ch_c[k])
      );
    end else begin : g_pass
      assign v_c[k]   = sq_v;
      assign acc_c[k] = sq_acc;
      assign ch_c[k]  = sq_ch;
    end
  end

  // n! times the inverse; the last multiplier stage is the output register.
  bmp_modmul #(.SIDE_W(CW)) u_out_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_c[0]),
    .a_i     (ch_c[0].fn),
    .b_i     (acc_c[0]),
    .side_i  (ch_c[0]),
    .valid_o (out_v),
    .prod_o  (out_prod),
    .side_o  (out_ch)
  );

  assign result_o.valid           = out_v;
  assign result_o.status_code     = out_ch.status;
  assign result_o.binomial_result = (out_ch.status == bmp_pkg::STATUS_OK) ? out_prod : '0;

  // Once the table is filled it stays filled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_ready |=> table_ready)
    else $error("factorial table lost its ready state");

  // A valid coefficient is never zero, since every factorial is a unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v && out_ch.status == bmp_pkg::STATUS_OK) |-> (out_prod != '0))
    else $error("zero coefficient on a valid query");

  // Results only flow after the fill has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v |-> table_ready)
    else $error("result before factorial table was ready");

endmodule
